@@ rtl/ffsa_pkg.sv @@
// shared types and constants for the free-list slot allocator
// depends on nothing; imported by every module of the allocator
package ffsa_pkg;

    // default geometry
    localparam int SLOTS_DEF = 64;
    localparam int POOLS_DEF = 2;

    // request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_EXHAUSTED = 2'd2
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear;   // clear one bitmap entry
        logic load;    // capture the request word
        logic read;    // read bitmap and ring for the captured word
        logic exec;    // update state and result registers
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;  // last bitmap entry is being cleared
    } stat_t;

endpackage

@@ rtl/ffsa_ctrl.sv @@
// controller state machine of the free-list slot allocator
// depends on ffsa_pkg; drives the command word of ffsa_dpath
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // result strobe follows the execute cycle
    assign done_next = (state_reg == S_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // commands
    always_comb
    begin
        cmd.clear = (state_reg == S_CLEAR);
        cmd.load  = (state_reg == S_IDLE) && start;
        cmd.read  = (state_reg == S_READ);
        cmd.exec  = (state_reg == S_EXEC);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

@@ rtl/ffsa_dpath.sv @@
// datapath of the free-list slot allocator: per-pool pointers, ring and bitmap memories
// depends on ffsa_pkg; commanded by ffsa_ctrl
module ffsa_dpath
    import ffsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int POOLS = POOLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        opcode,
    input  logic        pool,
    input  logic [5:0]  slot,
    output logic [5:0]  assigned_slot,
    output logic [1:0]  status,
    output logic [6:0]  layer_count
);

    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = SW + 1;
    localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int DEPTH = POOLS * SLOTS;
    localparam int AW    = $clog2(DEPTH);

    // captured request word
    logic          op_reg;
    logic [PW-1:0] pool_reg;
    logic [5:0]    slot_reg;
    logic          pool_ok_reg;

    // per-pool pointers and counts
    logic [SW-1:0] head_reg [POOLS];
    logic [SW-1:0] tail_reg [POOLS];
    logic [CW-1:0] fill_reg [POOLS];
    logic [CW-1:0] hw_reg   [POOLS];

    // memories
    logic [SW-1:0] ring_mem   [DEPTH];
    logic          bitmap_mem [DEPTH];
    logic [SW-1:0] ring_rd_reg;
    logic          bit_rd_reg;

    // bitmap clearing pass
    logic [AW-1:0] clr_reg;

    // results
    logic [5:0]    assigned_reg;
    status_t       status_reg;
    logic [6:0]    count_reg;

    // decoded request
    logic          slot_big;
    logic [SW-1:0] slot_idx;
    logic [SW-1:0] cur_head, cur_tail;
    logic [CW-1:0] cur_fill, cur_hw;
    logic [AW-1:0] ring_rd_addr, bit_rd_addr;

    // execute outcome
    logic [SW-1:0] head_next, tail_next, given;
    logic [CW-1:0] fill_next, hw_next;
    status_t       st_next;
    logic          ring_we;
    logic [AW-1:0] ring_wr_addr;
    logic          bit_we, bit_wd;
    logic [AW-1:0] bit_wr_addr;

    function automatic logic [SW-1:0] wrap_next(input logic [SW-1:0] p);
        return (p == SW'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [PW-1:0] pl,
                                               input logic [SW-1:0] ix);
        return AW'(int'(pl) * SLOTS + int'(ix));
    endfunction

    // capture request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode;
            pool_reg    <= PW'(pool);
            slot_reg    <= slot;
            pool_ok_reg <= (int'(pool) < POOLS);
        end
    end

    // current pool view
    always_comb
    begin
        slot_big     = (int'(slot_reg) >= SLOTS);
        slot_idx     = SW'(slot_reg);
        cur_head     = head_reg[pool_reg];
        cur_tail     = tail_reg[pool_reg];
        cur_fill     = fill_reg[pool_reg];
        cur_hw       = hw_reg[pool_reg];
        ring_rd_addr = pool_ok_reg ? mem_addr(pool_reg, cur_head) : '0;
        bit_rd_addr  = (pool_ok_reg && !slot_big) ? mem_addr(pool_reg, slot_idx) : '0;
    end

    // execute decision
    always_comb
    begin
        head_next    = cur_head;
        tail_next    = cur_tail;
        fill_next    = cur_fill;
        hw_next      = cur_hw;
        given        = '0;
        st_next      = ST_OK;
        ring_we      = 1'b0;
        ring_wr_addr = mem_addr(pool_reg, cur_tail);
        bit_we       = 1'b0;
        bit_wd       = 1'b0;
        bit_wr_addr  = '0;
        if (!pool_ok_reg)
        begin
            st_next = ST_EXHAUSTED;
            hw_next = '0;
        end
        else if (op_reg == OP_ALLOC)
        begin
            if (cur_fill != '0)
            begin
                given       = ring_rd_reg;
                head_next   = wrap_next(cur_head);
                fill_next   = cur_fill - 1'b1;
                bit_we      = 1'b1;
                bit_wr_addr = mem_addr(pool_reg, ring_rd_reg);
            end
            else if (int'(cur_hw) < SLOTS)
            begin
                given   = SW'(cur_hw);
                hw_next = cur_hw + 1'b1;
            end
            else
            begin
                st_next = ST_EXHAUSTED;
            end
        end
        else
        begin
            if (slot_big || bit_rd_reg)
            begin
                st_next = ST_IGNORED;
            end
            else
            begin
                ring_we     = 1'b1;
                tail_next   = wrap_next(cur_tail);
                fill_next   = cur_fill + 1'b1;
                bit_we      = 1'b1;
                bit_wd      = 1'b1;
                bit_wr_addr = mem_addr(pool_reg, slot_idx);
            end
        end
    end

    // per-pool state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOLS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
                hw_reg[i]   <= '0;
            end
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.exec && pool_ok_reg)
            begin
                head_reg[pool_reg] <= head_next;
                tail_reg[pool_reg] <= tail_next;
                fill_reg[pool_reg] <= fill_next;
                hw_reg[pool_reg]   <= hw_next;
            end
        end
    end

    assign stat.clear_last = (clr_reg == AW'(DEPTH - 1));

    // free ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.exec && ring_we)
        begin
            ring_mem[ring_wr_addr] <= slot_idx;
        end
        if (cmd.read)
        begin
            ring_rd_reg <= ring_mem[ring_rd_addr];
        end
    end

    // membership bitmap memory, cleared entry by entry after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            bitmap_mem[clr_reg] <= 1'b0;
        end
        else if (cmd.exec && bit_we)
        begin
            bitmap_mem[bit_wr_addr] <= bit_wd;
        end
        if (cmd.read)
        begin
            bit_rd_reg <= bitmap_mem[bit_rd_addr];
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            assigned_reg <= 6'(given);
            status_reg   <= st_next;
            count_reg    <= 7'(hw_next);
        end
    end

    assign assigned_slot = assigned_reg;
    assign status        = status_reg;
    assign layer_count   = count_reg;

endmodule

@@ rtl/fifo_free_list_slot_allocator.sv @@
// Free-list slot allocator, top level: controller plus datapath.
// A word accepted with start is captured, its ring and bitmap entries are read, and the
// execute step registers the result and done; a new word is taken only while busy is low.
// Reset: pointers and counts clear at once; the membership bitmap is then
// cleared one entry a cycle, busy high until all POOLS*SLOTS entries (128 by default) are clear.
// The receiver cannot stall: each result is shown for one cycle on done.
module fifo_free_list_slot_allocator
    import ffsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int POOLS = POOLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic        pool,
    input  logic [5:0]  slot,
    output logic        done,
    output logic [5:0]  assigned_slot,
    output logic [1:0]  status,
    output logic [6:0]  layer_count
);

    cmd_t  cmd;
    stat_t stat;

    // sequencing
    ffsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // pointers, free ring and bitmap
    ffsa_dpath #(
        .SLOTS (SLOTS),
        .POOLS (POOLS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .pool          (pool),
        .slot          (slot),
        .assigned_slot (assigned_slot),
        .status        (status),
        .layer_count   (layer_count)
    );

endmodule
